>>> src/ispe_pkg.sv
// Shared constants, types and helpers for the stable pitch estimator.
// Used by every module of the block; depends on nothing else.
package ispe_pkg;

   // Sample and configuration widths
   localparam int SAMPLE_BITS = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 15;
   localparam int ROT_W = 15;
   localparam int TOL_W = 11;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROTATION_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FORCE_TOLERANCE = 1'd1;

   // Reset values of the configuration registers
   localparam logic [ROT_W-1:0] ROT_RESET = 15'd200;
   localparam logic [TOL_W-1:0] TOL_RESET = 11'd154;

   // Scaling ratios: accel 7808/15625, gyro 896/1125
   localparam int ACC_NUM = 7808;
   localparam int ACC_DEN = 15625;
   localparam int ACC_LIM = 16384;
   localparam int GYR_NUM = 896;
   localparam int GYR_DEN = 1125;
   localparam int GYR_LIM = 26100;

   // Squared ratio used by the one-g window test
   localparam logic [27:0] NUM2 = 28'd244140625;
   localparam logic [25:0] DEN2 = 26'd60964864;

   // Square root and CORDIC sizing
   localparam int SQ_W = 32;
   localparam int SQRT_STEPS = 16;
   localparam int CW = 27;
   localparam int ZW = 33;
   localparam int TABLE_LEN = 24;
   localparam int CORDIC_STAGES_DEF = 16;

   // Arc tangent of 2^-i with a quarter turn equal to 2^30
   localparam logic signed [ZW-1:0] ATAN_TAB [0:TABLE_LEN-1] = '{
      33'sd536870912, 33'sd316933407, 33'sd167458908, 33'sd85004756,
      33'sd42667332, 33'sd21354465, 33'sd10679838, 33'sd5340245,
      33'sd2670163, 33'sd1335087, 33'sd667544, 33'sd333772,
      33'sd166886, 33'sd83443, 33'sd41722, 33'sd20861,
      33'sd10430, 33'sd5215, 33'sd2608, 33'sd1304,
      33'sd652, 33'sd326, 33'sd163, 33'sd81
   };

   // State handed from one square root cell to the next
   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [SQ_W-1:0] root;
   } sq_type;

   // State handed from one CORDIC cell to the next
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } cor_type;

   // Magnitude of a signed sample; the most negative value maps to 2^15.
   function automatic logic [SAMPLE_BITS-1:0] mag16(logic signed [SAMPLE_BITS-1:0] v);
      mag16 = v[SAMPLE_BITS-1] ? SAMPLE_BITS'(-v) : SAMPLE_BITS'(v);
   endfunction

endpackage

>>> src/ispe_scale.sv
// One channel of the count scaler: rounds |count| * NUM / DEN, saturates, restores sign.
// Three register stages; depends on ispe_pkg.
module ispe_scale #(
   parameter int NUM = ispe_pkg::ACC_NUM,
   parameter int DEN = ispe_pkg::ACC_DEN,
   parameter int LIM = ispe_pkg::ACC_LIM
) (
   input  logic                                    clock,
   input  logic                                    en,
   input  logic signed [ispe_pkg::SAMPLE_BITS-1:0] sample,
   output logic signed [ispe_pkg::SAMPLE_BITS-1:0] result
);
   import ispe_pkg::*;

   localparam int NW = 30;
   localparam int RW = 30;
   localparam int QW = 16;
   localparam int SHIFT = 40;
   localparam longint D2 = 2 * DEN;
   localparam logic [RW-1:0] RECIP = RW'((64'd1 << SHIFT) / D2);

   logic [NW-1:0] n1_ff, n1_in, n2_ff, rem;
   logic          neg1_ff, neg2_ff;
   logic [QW-1:0] q0_ff, q0_in, q, qs;
   logic [NW+RW-1:0] prod;
   logic signed [SAMPLE_BITS-1:0] result_ff, result_in;

   // Stage one: numerator 2*|v|*NUM + DEN so that the floor division rounds.
   assign n1_in = NW'(NW'(mag16(sample)) * NW'(2 * NUM)) + NW'(DEN);

   // Stage two: quotient estimate from the reciprocal, low by at most one.
   assign prod = NW'(n1_ff) * (NW + RW)'(RECIP);
   assign q0_in = QW'(prod >> SHIFT);

   // Stage three: one correction step, saturation and sign.
   always_comb begin
      rem = n2_ff - NW'(NW'(q0_ff) * NW'(D2));
      q = (rem >= NW'(D2)) ? q0_ff + QW'(1) : q0_ff;
      qs = (q > QW'(LIM)) ? QW'(LIM) : q;
      result_in = neg2_ff ? -$signed(qs) : $signed(qs);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_ff <= n1_in;
         neg1_ff <= sample[SAMPLE_BITS-1];
         n2_ff <= n1_ff;
         neg2_ff <= neg1_ff;
         q0_ff <= q0_in;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> src/ispe_sqrt_cell.sv
// One step of the restoring integer square root, registered.
// A row of these cells forms the root pipeline; depends on ispe_pkg.
module ispe_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic             clock,
   input  logic             en,
   input  ispe_pkg::sq_type cell_in,
   output ispe_pkg::sq_type cell_out
);
   import ispe_pkg::*;

   localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * STEP);

   sq_type          state_ff, state_in;
   logic [SQ_W-1:0] trial;

   // Subtract the trial value when it fits and fold the bit into the root.
   always_comb begin
      trial = cell_in.root + BIT;
      if (cell_in.rem >= trial) begin
         state_in.rem = cell_in.rem - trial;
         state_in.root = (cell_in.root >> 1) + BIT;
      end else begin
         state_in.rem = cell_in.rem;
         state_in.root = cell_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         state_ff <= state_in;
      end
   end

   assign cell_out = state_ff;

endmodule

>>> src/ispe_cordic_cell.sv
// One vectoring CORDIC micro-rotation, registered.
// A row of these cells drives y toward zero and sums the angle; depends on ispe_pkg.
module ispe_cordic_cell #(
   parameter int IDX = 0
) (
   input  logic              clock,
   input  logic              en,
   input  ispe_pkg::cor_type cell_in,
   output ispe_pkg::cor_type cell_out
);
   import ispe_pkg::*;

   cor_type              state_ff, state_in;
   logic signed [CW-1:0] xv, yv, xs, ys;
   logic signed [ZW-1:0] zv;

   // Rotate against the sign of y and accumulate the matching angle.
   always_comb begin
      xv = cell_in.x;
      yv = cell_in.y;
      zv = cell_in.z;
      xs = xv >>> IDX;
      ys = yv >>> IDX;
      if (yv > 0) begin
         state_in.x = xv + ys;
         state_in.y = yv - xs;
         state_in.z = zv + ATAN_TAB[IDX];
      end else begin
         state_in.x = xv - ys;
         state_in.y = yv + xs;
         state_in.z = zv - ATAN_TAB[IDX];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         state_ff <= state_in;
      end
   end

   assign cell_out = state_ff;

endmodule

>>> src/imu_stable_pitch_estimator_unit.sv
// Top level of the stillness-gated pitch estimator: front stages, window test,
// square root and CORDIC cell rows, and the result emitter. Depends on ispe_pkg and all cells.
//
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_stall    raw accel, gyro, device id, timestamp
// rsp      out        rsp_valid/rsp_stall    kind, scaled axes, pitch, device, time, last
// csr      in         csr_write              csr_index, csr_data
//
// On its way to the first result a sample passes one input register, one squaring
// stage, sixteen square root cells and one cell per CORDIC step.
// A sample that is not still gives only the raw result; a still sample also gives a pitch
// result, since the emitter sends the raw result first and the pitch result after it.
// Reset clears the valid bits and the emitter phase and loads the configuration registers with their reset values.
// The pipeline freezes while the last stage holds a sample and the output is stalled, and while the
// emitter sends the raw result of a still sample; req_stall is high in exactly those cycles.
module imu_stable_pitch_estimator_unit #(
   parameter int CORDIC_STAGES = ispe_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [ispe_pkg::SAMPLE_BITS-1:0] req_accel_x,
   input  logic signed [ispe_pkg::SAMPLE_BITS-1:0] req_accel_y,
   input  logic signed [ispe_pkg::SAMPLE_BITS-1:0] req_accel_z,
   input  logic signed [ispe_pkg::SAMPLE_BITS-1:0] req_gyro_x,
   input  logic signed [ispe_pkg::SAMPLE_BITS-1:0] req_gyro_y,
   input  logic signed [ispe_pkg::SAMPLE_BITS-1:0] req_gyro_z,
   input  logic [7:0]                              req_device_id,
   input  logic [47:0]                             req_sample_time,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_kind,
   output logic signed [15:0]                      rsp_scaled_ax,
   output logic signed [15:0]                      rsp_scaled_ay,
   output logic signed [15:0]                      rsp_scaled_az,
   output logic signed [15:0]                      rsp_scaled_gx,
   output logic signed [15:0]                      rsp_scaled_gy,
   output logic signed [15:0]                      rsp_scaled_gz,
   output logic signed [15:0]                      rsp_pitch,
   output logic [7:0]                              rsp_out_device,
   output logic [47:0]                             rsp_out_time,
   output logic                                    rsp_last,
   input  logic                                    csr_write,
   input  logic [ispe_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [ispe_pkg::CSR_DATA_W-1:0]         csr_data
);
   import ispe_pkg::*;

   localparam int SQ_LAST = 1 + SQRT_STEPS;
   localparam int LAST = SQ_LAST + CORDIC_STAGES;
   localparam int DEPTH = LAST + 1;
   localparam int SW = SAMPLE_BITS;

   typedef struct packed {
      logic signed [SW-1:0] ax;
      logic signed [15:0]   sax;
      logic signed [15:0]   say;
      logic signed [15:0]   saz;
      logic signed [15:0]   sgx;
      logic signed [15:0]   sgy;
      logic signed [15:0]   sgz;
      logic [7:0]           dev;
      logic [47:0]          ts;
      logic                 gyro_still;
      logic                 force_ok;
   } side_type;

   typedef struct packed {
      logic                 kind;
      logic signed [15:0]   sax;
      logic signed [15:0]   say;
      logic signed [15:0]   saz;
      logic signed [15:0]   sgx;
      logic signed [15:0]   sgy;
      logic signed [15:0]   sgz;
      logic signed [15:0]   pitch;
      logic [7:0]           dev;
      logic [47:0]          ts;
      logic                 last;
   } rsp_type;

   logic [ROT_W-1:0] rot_limit_ff;
   logic [TOL_W-1:0] force_tol_ff;
   logic [23:0]      hi_sq_ff;
   logic [20:0]      lo_sq_ff;
   logic             lo_en_ff, lo_en2_ff;
   logic [51:0]      hi_lim_ff;
   logic [48:0]      lo_lim_ff;
   logic [11:0]      hi_val;
   logic [10:0]      lo_val;

   logic                 en;
   logic [DEPTH-1:0]     valid_ff, valid_in;
   side_type             side_ff [0:DEPTH-1];
   side_type             side_in [0:DEPTH-1];
   logic signed [SW-1:0] s0_ay_ff, s0_az_ff, s0_gx_ff, s0_gy_ff, s0_gz_ff;

   logic [SW-1:0]   mx, my, mz;
   logic [SQ_W-1:0] sum_yz_ff, sum_yz_in, sum_all_ff, sum_all_in;
   logic [57:0]     force_prod_ff;
   logic            gyro_still, force_ok;
   logic signed [15:0] sc_ax, sc_ay, sc_az, sc_gx, sc_gy, sc_gz;

   sq_type  sq_link  [0:SQRT_STEPS];
   cor_type cor_link [0:CORDIC_STAGES];

   logic                 out_load, last_valid, last_still, done;
   logic                 phase_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;
   logic signed [ZW-1:0] z_round;
   logic signed [15:0]   pitch_val;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_limit_ff <= ROT_RESET;
         force_tol_ff <= TOL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_ROTATION_LIMIT: rot_limit_ff <= csr_data[ROT_W-1:0];
            REG_FORCE_TOLERANCE: force_tol_ff <= csr_data[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // Window bounds of the one-g test in squared, scaled-count units.
   // After a write the squares are registered first and the limits are registered from them.
   assign hi_val = 12'(force_tol_ff) + 12'd1024;
   assign lo_val = 11'd1024 - force_tol_ff;
   always_ff @(posedge clock) begin
      hi_sq_ff <= 24'(hi_val) * 24'(hi_val);
      lo_sq_ff <= 21'(lo_val) * 21'(lo_val);
      lo_en_ff <= (force_tol_ff < 11'd1024);
      hi_lim_ff <= 52'(hi_sq_ff) * 52'(NUM2);
      lo_lim_ff <= 49'(lo_sq_ff) * 49'(NUM2);
      lo_en2_ff <= lo_en_ff;
   end

   // The pipeline moves unless the last stage holds a sample the emitter cannot finish.
   assign en = !valid_ff[LAST] || done;
   assign req_stall = !en;

   assign valid_in = {valid_ff[DEPTH-2:0], req_valid};
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   // Input register and the side data line that runs beside the cell rows.
   always_comb begin
      side_in[0].ax = req_accel_x;
      side_in[0].sax = '0;
      side_in[0].say = '0;
      side_in[0].saz = '0;
      side_in[0].sgx = '0;
      side_in[0].sgy = '0;
      side_in[0].sgz = '0;
      side_in[0].dev = req_device_id;
      side_in[0].ts = req_sample_time;
      side_in[0].gyro_still = 1'b0;
      side_in[0].force_ok = 1'b0;
      for (int k = 1; k < DEPTH; k++) begin
         side_in[k] = side_ff[k-1];
         if (k == 1) begin
            side_in[k].gyro_still = gyro_still;
         end
         if (k == 3) begin
            side_in[k].force_ok = force_ok;
         end
         if (k == 4) begin
            side_in[k].sax = sc_ax;
            side_in[k].say = sc_ay;
            side_in[k].saz = sc_az;
            side_in[k].sgx = sc_gx;
            side_in[k].sgy = sc_gy;
            side_in[k].sgz = sc_gz;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_in;
         s0_ay_ff <= req_accel_y;
         s0_az_ff <= req_accel_z;
         s0_gx_ff <= req_gyro_x;
         s0_gy_ff <= req_gyro_y;
         s0_gz_ff <= req_gyro_z;
      end
   end

   // Rotation gate on the stored sample.
   assign gyro_still = (mag16(s0_gx_ff) <= SW'(rot_limit_ff))
                    && (mag16(s0_gy_ff) <= SW'(rot_limit_ff))
                    && (mag16(s0_gz_ff) <= SW'(rot_limit_ff));

   // Squares of the accel axes: y plus z feeds the root, all three the window test.
   always_comb begin
      mx = mag16(side_ff[0].ax);
      my = mag16(s0_ay_ff);
      mz = mag16(s0_az_ff);
      sum_yz_in = SQ_W'(SQ_W'(my) * SQ_W'(my)) + SQ_W'(SQ_W'(mz) * SQ_W'(mz));
      sum_all_in = sum_yz_in + SQ_W'(SQ_W'(mx) * SQ_W'(mx));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_yz_ff <= sum_yz_in;
         sum_all_ff <= sum_all_in;
         force_prod_ff <= 58'(sum_all_ff) * 58'(DEN2);
      end
   end

   // The window test compares cross-multiplied, so no division is needed.
   assign force_ok = (force_prod_ff <= 58'(hi_lim_ff))
                  && (!lo_en2_ff || (force_prod_ff >= 58'(lo_lim_ff)));

   // Count scalers, one per axis.
   ispe_scale #(.NUM(ACC_NUM), .DEN(ACC_DEN), .LIM(ACC_LIM)) u_scale_ax (
      .clock(clock), .en(en), .sample(side_ff[0].ax), .result(sc_ax));
   ispe_scale #(.NUM(ACC_NUM), .DEN(ACC_DEN), .LIM(ACC_LIM)) u_scale_ay (
      .clock(clock), .en(en), .sample(s0_ay_ff), .result(sc_ay));
   ispe_scale #(.NUM(ACC_NUM), .DEN(ACC_DEN), .LIM(ACC_LIM)) u_scale_az (
      .clock(clock), .en(en), .sample(s0_az_ff), .result(sc_az));
   ispe_scale #(.NUM(GYR_NUM), .DEN(GYR_DEN), .LIM(GYR_LIM)) u_scale_gx (
      .clock(clock), .en(en), .sample(s0_gx_ff), .result(sc_gx));
   ispe_scale #(.NUM(GYR_NUM), .DEN(GYR_DEN), .LIM(GYR_LIM)) u_scale_gy (
      .clock(clock), .en(en), .sample(s0_gy_ff), .result(sc_gy));
   ispe_scale #(.NUM(GYR_NUM), .DEN(GYR_DEN), .LIM(GYR_LIM)) u_scale_gz (
      .clock(clock), .en(en), .sample(s0_gz_ff), .result(sc_gz));

   // Square root row: one bit of the root per cell.
   assign sq_link[0].rem = sum_yz_ff;
   assign sq_link[0].root = '0;
   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      ispe_sqrt_cell #(.STEP(j)) u_cell (
         .clock(clock), .en(en), .cell_in(sq_link[j]), .cell_out(sq_link[j+1]));
   end

   // CORDIC row: x starts at the root, y at accel x, both scaled by 256.
   assign cor_link[0].x = CW'($signed({1'b0, sq_link[SQRT_STEPS].root[15:0], 8'd0}));
   assign cor_link[0].y = CW'($signed({side_ff[SQ_LAST].ax, 8'd0}));
   assign cor_link[0].z = '0;
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      ispe_cordic_cell #(.IDX(i)) u_cell (
         .clock(clock), .en(en), .cell_in(cor_link[i]), .cell_out(cor_link[i+1]));
   end

   // Round the angle into Q1.14 and saturate; a zero x axis gives a level pitch.
   always_comb begin
      z_round = (cor_link[CORDIC_STAGES].z + ZW'(32768)) >>> 16;
      if (side_ff[LAST].ax == '0) begin
         pitch_val = '0;
      end else if (z_round > ZW'(16384)) begin
         pitch_val = 16'sd16384;
      end else if (z_round < -ZW'(16384)) begin
         pitch_val = -16'sd16384;
      end else begin
         pitch_val = 16'(z_round);
      end
   end

   // Emitter: raw transaction first, then the pitch transaction for a still sample.
   assign last_valid = valid_ff[LAST];
   assign last_still = side_ff[LAST].gyro_still && side_ff[LAST].force_ok;
   assign out_load = !rsp_valid_ff || !rsp_stall;
   assign done = out_load && (phase_ff || !last_still);

   always_comb begin
      rsp_in.dev = side_ff[LAST].dev;
      rsp_in.ts = side_ff[LAST].ts;
      if (phase_ff) begin
         rsp_in.kind = 1'b1;
         rsp_in.sax = '0;
         rsp_in.say = '0;
         rsp_in.saz = '0;
         rsp_in.sgx = '0;
         rsp_in.sgy = '0;
         rsp_in.sgz = '0;
         rsp_in.pitch = pitch_val;
         rsp_in.last = 1'b1;
      end else begin
         rsp_in.kind = 1'b0;
         rsp_in.sax = side_ff[LAST].sax;
         rsp_in.say = side_ff[LAST].say;
         rsp_in.saz = side_ff[LAST].saz;
         rsp_in.sgx = side_ff[LAST].sgx;
         rsp_in.sgy = side_ff[LAST].sgy;
         rsp_in.sgz = side_ff[LAST].sgz;
         rsp_in.pitch = '0;
         rsp_in.last = !last_still;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= last_valid;
         if (last_valid) begin
            phase_ff <= !phase_ff && last_still;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && last_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_ff.kind;
   assign rsp_scaled_ax = rsp_ff.sax;
   assign rsp_scaled_ay = rsp_ff.say;
   assign rsp_scaled_az = rsp_ff.saz;
   assign rsp_scaled_gx = rsp_ff.sgx;
   assign rsp_scaled_gy = rsp_ff.sgy;
   assign rsp_scaled_gz = rsp_ff.sgz;
   assign rsp_pitch = rsp_ff.pitch;
   assign rsp_out_device = rsp_ff.dev;
   assign rsp_out_time = rsp_ff.ts;
   assign rsp_last = rsp_ff.last;

   // A pitch transaction always closes its sample.
   a_pitch_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_last)
      else $error("pitch transaction without last");

   // A raw transaction that is not last is followed at once by its pitch transaction.
   a_pitch_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_kind && !rsp_last |=> rsp_valid && rsp_kind)
      else $error("pitch transaction missing after raw transaction");

   // Input stalls only when the last stage holds a sample.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> valid_ff[LAST])
      else $error("input stalled with an empty last stage");

endmodule
